// File: src/quaternion_product_rotate_unit_top_macros.svh
// assertion macros used by the checker file
`ifndef QUATERNION_PRODUCT_ROTATE_UNIT_TOP_MACROS_SVH
`define QUATERNION_PRODUCT_ROTATE_UNIT_TOP_MACROS_SVH

// implication checked outside reset
`define QPRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qpru assertion failed");

// next-cycle implication checked outside reset
`define QPRU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qpru assertion failed");

// next-cycle implication that also holds across reset
`define QPRU_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("qpru assertion failed");

`endif

// File: src/qpru_pkg.sv
// types, constants and arithmetic helpers of the quaternion unit
`default_nettype none
package qpru_pkg;

  localparam int CW    = 16;          // component width
  localparam int FB    = 14;          // fraction bits
  localparam int PW    = 2 * CW;      // product width
  localparam int SUMW  = PW + 1;      // sum of four squares
  localparam int NW    = PW + 2;      // even-padded radicand
  localparam int SQST  = NW / 2;      // root digits
  localparam int LW    = SQST;        // root width
  localparam int REMW  = CW + 4;      // root remainder
  localparam int NUMW  = CW + 1 + FB; // dividend width
  localparam int DVST  = CW;          // quotient bits

  localparam logic [1:0] FUNC_PROD = 2'd0;
  localparam logic [1:0] FUNC_NORM = 2'd1;
  localparam logic [1:0] FUNC_ROT  = 2'd2;

  typedef struct packed {
    logic [1:0]           func;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] b_w;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic signed [CW-1:0] r_w;
    logic                 zero_length;
  } out_item_t;

  typedef struct packed {
    logic prod;
    logic norm;
    logic rot;
  } cls_t;

  // front to back: head of the request queue
  typedef struct packed {
    logic     valid;
    cls_t     cls;
    in_item_t item;
  } fb_t;

  // data that rides along the root and divide stages
  typedef struct packed {
    cls_t                 cls;
    logic [2:0][CW-1:0]   rot;
    logic [3:0][CW-1:0]   t;
  } side_t;

  localparam logic signed [PW+1:0] RND = (PW + 2)'(1 << (FB - 1));

  function automatic logic signed [CW-1:0] sat(input logic signed [PW+1:0] v);
    logic [PW+2-CW:0] hi;
    hi = v[PW+1:CW-1];
    if ((&hi) || !(|hi)) begin
      return v[CW-1:0];
    end else if (v[PW+1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [CW-1:0] round4(input logic signed [PW-1:0] t0,
                                                   input logic signed [PW-1:0] t1,
                                                   input logic signed [PW-1:0] t2,
                                                   input logic signed [PW-1:0] t3);
    logic signed [PW+1:0] s;
    s = (PW + 2)'(t0) + (PW + 2)'(t1) + (PW + 2)'(t2) + (PW + 2)'(t3) + RND;
    return sat(s >>> FB);
  endfunction

endpackage
`default_nettype wire

// File: src/quaternion_product_rotate_unit_top.sv
// top level of the quaternion product, normalize and rotate unit
// throughput: one request per cycle while the result queue is not full;
// the 17-stage root and 16-stage divider are fully pipelined
// the back pipeline advances as a whole and holds only while the result queue is full
// reset (rst_n low, synchronous) empties both queues and clears every pipeline valid bit
// no clearing pass: the block accepts requests in the first cycle after reset
`default_nettype none
module quaternion_product_rotate_unit_top import qpru_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_item_t  in_item,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_item_t      out_item
);

  fb_t       fb;           // head of the request queue plus its class
  logic      adv;          // whole back pipeline steps forward
  logic      res_valid;
  out_item_t res;
  logic      oq_full;

  // front: buffers requests and decodes the function code
  qpru_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .take    (adv),
    .fb      (fb)
  );

  // back pipeline steps whenever the result queue has a free slot
  assign adv = !oq_full;

  qpru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .fb        (fb),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue decouples the pipeline from the consumer
  qpru_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid && adv),
    .data  (res),
    .full  (oq_full),
    .empty (out_empty),
    .pop   (out_pop),
    .head  (out_item)
  );

endmodule
`default_nettype wire

// File: src/qpru_front.sv
// front: request queue that classifies each item by its function code
`default_nettype none
module qpru_front import qpru_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_item,
  output logic          in_full,
  input  wire logic     take,
  output fb_t           fb
);

  in_item_t   item_r [2];
  cls_t       cls_r  [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cls_t       cls_in;
  logic       wr_en, rd_en;

  always_comb begin
    cls_in = '0;
    unique case (in_item.func)
      FUNC_PROD: cls_in.prod = 1'b1;
      FUNC_NORM: cls_in.norm = 1'b1;
      FUNC_ROT:  cls_in.rot  = 1'b1;
      default:   cls_in = '0;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign wr_en   = in_push && !in_full;
  assign rd_en   = take && (cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, wr_en} - {1'b0, rd_en});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      item_r[wr_ptr_r] <= in_item;
      cls_r[wr_ptr_r]  <= cls_in;
    end
  end

  assign fb.valid = (cnt_r != 2'd0);
  assign fb.cls   = cls_r[rd_ptr_r];
  assign fb.item  = item_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: src/qpru_back.sv
// back: product, rotate, square-root and divide pipeline
`default_nettype none
module qpru_back import qpru_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire fb_t  fb,
  output logic      res_valid,
  output out_item_t res
);

  // p1: captured request
  logic                 v1_r;
  cls_t                 cls1_r;
  logic [3:0][CW-1:0]   a1_r, b1_r;

  // p2: all a*b products
  logic                 v2_r;
  cls_t                 cls2_r;
  logic [3:0][CW-1:0]   a2_r;
  logic signed [PW-1:0] p2_r [4][4];

  // p3: rounded first stage
  logic                 v3_r;
  cls_t                 cls3_r;
  logic [3:0][CW-1:0]   a3_r, t3_r;
  logic [3:0][CW-1:0]   t3_nxt;

  // p4: second products and squares
  logic                 v4_r;
  cls_t                 cls4_r;
  logic [3:0][CW-1:0]   t4_r;
  logic signed [PW-1:0] m4_r [4][4];
  logic [PW-1:0]        sq4_r [4];

  // root stages
  logic                 sq_v_r    [SQST+1];
  side_t                sq_side_r [SQST+1];
  logic [NW-1:0]        sq_n_r    [SQST+1];
  logic [REMW-1:0]      sq_rem_r  [SQST+1];
  logic [LW-1:0]        sq_root_r [SQST+1];
  side_t                side5;

  // divide stages
  logic                 dv_v_r    [DVST+1];
  side_t                dv_side_r [DVST+1];
  logic [LW-1:0]        dv_len_r  [DVST+1];
  logic [NUMW-1:0]      dv_num_r  [DVST+1][4];
  logic [LW-1:0]        dv_rem_r  [DVST+1][4];
  logic [CW-1:0]        dv_q_r    [DVST+1][4];
  logic                 dv_neg_r  [DVST+1][4];
  logic                 dv_ovf_r  [DVST+1][4];

  logic [CW-1:0]        lane_res [4];
  logic                 zl;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= fb.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls1_r <= fb.cls;
      a1_r   <= {fb.item.a_w, fb.item.a_z, fb.item.a_y, fb.item.a_x};
      b1_r   <= {fb.item.b_w, fb.item.b_z, fb.item.b_y, fb.item.b_x};
      cls2_r <= cls1_r;
      a2_r   <= a1_r;
      cls3_r <= cls2_r;
      a3_r   <= a2_r;
      t3_r   <= t3_nxt;
      cls4_r <= cls3_r;
      t4_r   <= t3_r;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_mul
    for (genvar j = 0; j < 4; j++) begin : g_mulj
      always_ff @(posedge clk) begin
        if (adv) begin
          p2_r[i][j] <= $signed(a1_r[i]) * $signed(b1_r[j]);
          m4_r[i][j] <= $signed(t3_r[i]) * $signed(a3_r[j]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq4_r[i] <= PW'($signed(t3_r[i]) * $signed(t3_r[i]));
      end
    end
  end

  // first rounding: hamilton product or rotate half-product (index x0 y1 z2 w3); normalize passes a unrounded
  always_comb begin
    t3_nxt = '0;
    if (cls2_r.prod) begin
      t3_nxt[0] = round4(p2_r[3][0], p2_r[0][3], p2_r[1][2], -p2_r[2][1]);
      t3_nxt[1] = round4(p2_r[3][1], -p2_r[0][2], p2_r[1][3], p2_r[2][0]);
      t3_nxt[2] = round4(p2_r[3][2], p2_r[0][1], -p2_r[1][0], p2_r[2][3]);
      t3_nxt[3] = round4(p2_r[3][3], -p2_r[0][0], -p2_r[1][1], -p2_r[2][2]);
    end else if (cls2_r.rot) begin
      t3_nxt[0] = round4(p2_r[3][0], p2_r[1][2], -p2_r[2][1], '0);
      t3_nxt[1] = round4(p2_r[3][1], p2_r[2][0], -p2_r[0][2], '0);
      t3_nxt[2] = round4(p2_r[3][2], p2_r[0][1], -p2_r[1][0], '0);
      t3_nxt[3] = round4(p2_r[0][0], p2_r[1][1], p2_r[2][2], '0);
    end else if (cls2_r.norm) begin
      t3_nxt = a2_r;
    end
  end

  // second rotate rounding and length squared feed the root pipeline
  always_comb begin
    side5.cls    = cls4_r;
    side5.t      = t4_r;
    side5.rot[0] = round4(m4_r[3][0], m4_r[0][3], -m4_r[1][2], m4_r[2][1]);
    side5.rot[1] = round4(m4_r[3][1], m4_r[1][3], -m4_r[2][0], m4_r[0][2]);
    side5.rot[2] = round4(m4_r[3][2], m4_r[2][3], -m4_r[0][1], m4_r[1][0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= side5;
      sq_n_r[0]    <= NW'(SUMW'(sq4_r[0]) + SUMW'(sq4_r[1]) + SUMW'(sq4_r[2])
                          + SUMW'(sq4_r[3]));
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // one root digit per stage
  for (genvar k = 0; k < SQST; k++) begin : g_sqrt
    logic [REMW-1:0] rem_sh, test;
    logic            ge;
    assign rem_sh = {sq_rem_r[k][REMW-3:0], sq_n_r[k][NW-1-2*k -: 2]};
    assign test   = REMW'({sq_root_r[k], 2'b01});
    assign ge     = (rem_sh >= test);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_n_r[k+1]    <= sq_n_r[k];
        sq_rem_r[k+1]  <= ge ? REMW'(rem_sh - test) : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][LW-2:0], ge};
      end
    end
  end

  // divide setup: magnitude, dividend, overflow check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= sq_side_r[SQST];
      dv_len_r[0]  <= sq_root_r[SQST];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic signed [CW:0] te;
    logic [CW:0]        mag;
    logic [NUMW-1:0]    num0;
    assign te   = {sq_side_r[SQST].t[l][CW-1], sq_side_r[SQST].t[l]};
    assign mag  = te[CW] ? (CW + 1)'(-te) : te;
    assign num0 = {mag, {FB{1'b0}}};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_num_r[0][l] <= num0;
        dv_rem_r[0][l] <= LW'(num0[NUMW-1:CW]);
        dv_q_r[0][l]   <= '0;
        dv_neg_r[0][l] <= te[CW];
        dv_ovf_r[0][l] <= ((2*CW+2)'(num0) >= (2*CW+2)'({sq_root_r[SQST], {CW{1'b0}}}));
      end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < DVST; k++) begin : g_div
      logic [LW:0] rem2;
      logic        ge;
      assign rem2 = {dv_rem_r[k][l], dv_num_r[k][l][CW-1-k]};
      assign ge   = (rem2 >= {1'b0, dv_len_r[k]});

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_num_r[k+1][l] <= dv_num_r[k][l];
          dv_rem_r[k+1][l] <= ge ? LW'(rem2 - {1'b0, dv_len_r[k]}) : LW'(rem2);
          dv_q_r[k+1][l]   <= {dv_q_r[k][l][CW-2:0], ge};
          dv_neg_r[k+1][l] <= dv_neg_r[k][l];
          dv_ovf_r[k+1][l] <= dv_ovf_r[k][l];
        end
      end
    end

    always_comb begin
      if (dv_ovf_r[DVST][l] || dv_q_r[DVST][l][CW-1]) begin
        lane_res[l] = dv_neg_r[DVST][l] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        lane_res[l] = dv_neg_r[DVST][l] ? CW'(-dv_q_r[DVST][l]) : dv_q_r[DVST][l];
      end
    end
  end

  for (genvar k = 0; k < DVST; k++) begin : g_dvctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[k+1] <= dv_side_r[k];
        dv_len_r[k+1]  <= dv_len_r[k];
      end
    end
  end

  assign zl        = (dv_len_r[DVST] == '0);
  assign res_valid = dv_v_r[DVST];

  always_comb begin
    res = '0;
    if (dv_side_r[DVST].cls.rot) begin
      res.r_x = dv_side_r[DVST].rot[0];
      res.r_y = dv_side_r[DVST].rot[1];
      res.r_z = dv_side_r[DVST].rot[2];
    end else if ((dv_side_r[DVST].cls.prod || dv_side_r[DVST].cls.norm) && !zl) begin
      res.r_x = lane_res[0];
      res.r_y = lane_res[1];
      res.r_z = lane_res[2];
      res.r_w = lane_res[3];
    end else if (dv_side_r[DVST].cls.prod || dv_side_r[DVST].cls.norm) begin
      res.zero_length = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: src/qpru_outq.sv
// two-entry result queue
`default_nettype none
module qpru_outq import qpru_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t data,
  output logic           full,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      head
);

  out_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, wr_en} - {1'b0, rd_en});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= data;
    end
  end

  assign head = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: src/qpru_checker.sv
// port-level checker of the quaternion unit and its bind
`default_nettype none
`include "quaternion_product_rotate_unit_top_macros.svh"
module qpru_checker import qpru_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_item
);

  `QPRU_ASSERT_RST(a_reset_clears, !rst_n, out_empty && !in_full)

  `QPRU_ASSERT_NXT(a_hold_result, !out_empty && !out_pop, !out_empty && $stable(out_item))

  // bits above the flag are the four components
  `QPRU_ASSERT_IMP(a_zero_len, !out_empty && out_item.zero_length, out_item[4*CW:1] == '0)

endmodule

bind quaternion_product_rotate_unit_top qpru_checker u_qpru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);
`default_nettype wire
